>>> rtl/core/sliding_window_statistics_unit_assert.svh
// Assertion macros for the checker of the sliding window statistics unit.
`ifndef SLIDING_WINDOW_STATISTICS_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_STATISTICS_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window statistics check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window statistics check failed");

`endif

>>> rtl/core/sws_pkg.sv
package sws_pkg;

   // Default capacity of the sample store.
   localparam int WINDOW_MAX_DEFAULT = 64;

   // Field widths of the item formats.
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 38;
   localparam int MEAN_W   = 40;
   localparam int DEV_W    = 40;
   localparam int CNT_W    = 7;
   localparam int RSP_W    = 128;

   // Reset value of the window length register.
   localparam logic [CNT_W-1:0] LENGTH_RESET = 7'd16;

   // Internal arithmetic widths.
   localparam int SQ_W    = 2 * SAMPLE_W;
   localparam int QSUM_W  = SQ_W + CNT_W - 2;       // sum of squares, at most 127 * 2^62
   localparam int PROD_W  = 76;                     // n * sum of squares and sum squared
   localparam int FRAC_SH = 16;                     // Q8 squared
   localparam int DIV_W   = PROD_W + FRAC_SH;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int ROOT_W  = DIV_W / 2;
   localparam int REM_W   = ROOT_W + 2;
   localparam int STEP_W  = 7;
   localparam int DIV_STEPS  = DIV_W;
   localparam int ROOT_STEPS = ROOT_W;

   // Operations that the controller asks of the datapath.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ,
      CMD_DROP,
      CMD_DROPQ,
      CMD_PUSH,
      CMD_PUSHQ,
      CMD_MEAN_INIT,
      CMD_DIV_STEP,
      CMD_MEAN_SAVE,
      CMD_MULN_INIT,
      CMD_MUL_STEP,
      CMD_MULS_INIT,
      CMD_VAR_INIT,
      CMD_ROOT_INIT,
      CMD_ROOT_STEP,
      CMD_OUT
   } cmd_type;

   // Status reported by the datapath.
   typedef struct packed {
      logic drop_needed;
      logic mul_busy;
      logic dev_needed;
   } status_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DROP,
      ST_DROPQ,
      ST_PUSH,
      ST_PUSHQ,
      ST_MEAN_INIT,
      ST_MEAN_DIV,
      ST_MEAN_SAVE,
      ST_MULN_INIT,
      ST_MULN,
      ST_MULS_INIT,
      ST_MULS,
      ST_VAR_INIT,
      ST_VAR_DIV,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_OUT
   } state_type;

endpackage

>>> rtl/core/sws_datapath.sv
module sws_datapath #(
   parameter int WINDOW_MAX = sws_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [sws_pkg::CNT_W-1:0]     csr_wdata,
   input  logic [sws_pkg::SAMPLE_W-1:0]  req_tdata,
   input  sws_pkg::cmd_type              cmd,
   output sws_pkg::status_type           status,
   output logic [sws_pkg::RSP_W-1:0]     rsp_tdata
);

   localparam int PW = $clog2(WINDOW_MAX);
   localparam int AW = 10;

   // Sample store, a ring from the oldest entry at head.
   logic signed [sws_pkg::SAMPLE_W-1:0] mem [WINDOW_MAX];

   logic [sws_pkg::CNT_W-1:0]           length_ff;
   logic [PW-1:0]                       head_ff, head_in;
   logic [sws_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [sws_pkg::CNT_W-1:0]           phase_ff, phase_in;
   logic signed [sws_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [sws_pkg::QSUM_W-1:0]          qsum_ff, qsum_in;
   logic signed [sws_pkg::SAMPLE_W-1:0] sample_ff, old_ff;
   logic [sws_pkg::SQ_W-1:0]            sq_ff;
   logic [sws_pkg::PROD_W-1:0]          acc_ff, acc_in, mula_ff, mula_in, t_ff;
   logic [sws_pkg::SUM_W-1:0]           mulb_ff, mulb_in;
   logic [sws_pkg::DIV_W-1:0]           num_ff, num_in;
   logic [sws_pkg::DEN_W-1:0]           rem_ff, rem_in, den_ff, den_in;
   logic [sws_pkg::DIV_W-1:0]           rad_ff, rad_in;
   logic [sws_pkg::ROOT_W-1:0]          root_ff, root_in;
   logic [sws_pkg::REM_W-1:0]           rrem_ff, rrem_in;
   logic [sws_pkg::MEAN_W-1:0]          mean_ff;
   logic [sws_pkg::RSP_W-1:0]           out_ff;

   logic [sws_pkg::CNT_W-1:0]           eff_len;
   logic [AW-1:0]                       tail_sum;
   logic [PW-1:0]                       tail;
   logic signed [sws_pkg::SAMPLE_W-1:0] mul_src;
   logic signed [sws_pkg::SQ_W-1:0]     sq_prod;
   logic                                neg;
   logic [sws_pkg::SUM_W-1:0]           mag;
   logic [sws_pkg::DEN_W:0]             dtrial;
   logic                                dge;
   logic [sws_pkg::REM_W+1:0]           rtrial, rcand;
   logic                                rge;
   logic [sws_pkg::CNT_W:0]             phase_inc;
   logic [sws_pkg::MEAN_W-1:0]          quot;
   logic                                dev_ok;

   // Effective window length: zero acts as one, clamp to the store size.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = sws_pkg::CNT_W'(1);
      end else if (int'(length_ff) > WINDOW_MAX) begin
         eff_len = sws_pkg::CNT_W'(WINDOW_MAX);
      end else begin
         eff_len = length_ff;
      end
   end

   // Write position behind the newest sample.
   always_comb begin
      tail_sum = AW'(head_ff) + AW'(count_ff);
      if (tail_sum >= AW'(WINDOW_MAX)) begin
         tail_sum = tail_sum - AW'(WINDOW_MAX);
      end
      tail = tail_sum[PW-1:0];
   end

   // Shared arithmetic terms.
   always_comb begin
      mul_src  = (cmd == sws_pkg::CMD_DROP) ? old_ff : sample_ff;
      sq_prod  = mul_src * mul_src;
      neg      = sum_ff[sws_pkg::SUM_W-1];
      mag      = neg ? sws_pkg::SUM_W'(-sum_ff) : sws_pkg::SUM_W'(sum_ff);
      dtrial   = {rem_ff, num_ff[sws_pkg::DIV_W-1]};
      dge      = dtrial >= {1'b0, den_ff};
      rcand    = {rrem_ff, rad_ff[sws_pkg::DIV_W-1 -: 2]};
      rtrial   = (sws_pkg::REM_W+2)'({root_ff, 2'b01});
      rge      = rcand >= rtrial;
      phase_inc = {1'b0, phase_ff} + 1'b1;
      quot     = num_ff[sws_pkg::MEAN_W-1:0];
      dev_ok   = count_ff >= sws_pkg::CNT_W'(2);
   end

   // Next values of the datapath registers for each operation.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      sum_in   = sum_ff;
      qsum_in  = qsum_ff;
      acc_in   = acc_ff;
      mula_in  = mula_ff;
      mulb_in  = mulb_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      rrem_in  = rrem_ff;
      unique case (cmd)
         sws_pkg::CMD_DROP: begin
            sum_in   = sum_ff - sws_pkg::SUM_W'(old_ff);
            count_in = count_ff - 1'b1;
            head_in  = (AW'(head_ff) == AW'(WINDOW_MAX - 1)) ? '0 : head_ff + 1'b1;
         end
         sws_pkg::CMD_DROPQ: begin
            qsum_in = qsum_ff - sws_pkg::QSUM_W'(sq_ff);
         end
         sws_pkg::CMD_PUSH: begin
            sum_in   = sum_ff + sws_pkg::SUM_W'(sample_ff);
            count_in = count_ff + 1'b1;
            phase_in = (phase_inc >= {1'b0, eff_len}) ? '0 : phase_inc[sws_pkg::CNT_W-1:0];
         end
         sws_pkg::CMD_PUSHQ: begin
            qsum_in = qsum_ff + sws_pkg::QSUM_W'(sq_ff);
         end
         sws_pkg::CMD_MEAN_INIT: begin
            num_in = sws_pkg::DIV_W'({mag, 9'd0}) + sws_pkg::DIV_W'(count_ff);
            den_in = sws_pkg::DEN_W'({count_ff, 1'b0});
            rem_in = '0;
         end
         sws_pkg::CMD_DIV_STEP: begin
            rem_in = dge ? sws_pkg::DEN_W'(dtrial - {1'b0, den_ff})
                         : dtrial[sws_pkg::DEN_W-1:0];
            num_in = {num_ff[sws_pkg::DIV_W-2:0], dge};
         end
         sws_pkg::CMD_MULN_INIT: begin
            acc_in  = '0;
            mula_in = sws_pkg::PROD_W'(qsum_ff);
            mulb_in = sws_pkg::SUM_W'(count_ff);
         end
         sws_pkg::CMD_MUL_STEP: begin
            if (mulb_ff[0]) begin
               acc_in = acc_ff + mula_ff;
            end
            mula_in = {mula_ff[sws_pkg::PROD_W-2:0], 1'b0};
            mulb_in = {1'b0, mulb_ff[sws_pkg::SUM_W-1:1]};
         end
         sws_pkg::CMD_MULS_INIT: begin
            acc_in  = '0;
            mula_in = sws_pkg::PROD_W'(mag);
            mulb_in = mag;
         end
         sws_pkg::CMD_VAR_INIT: begin
            num_in = {t_ff - acc_ff, {sws_pkg::FRAC_SH{1'b0}}};
            den_in = {7'd0, count_ff} * {7'd0, count_ff - 1'b1};
            rem_in = '0;
         end
         sws_pkg::CMD_ROOT_INIT: begin
            rad_in  = num_ff;
            root_in = '0;
            rrem_in = '0;
         end
         sws_pkg::CMD_ROOT_STEP: begin
            rrem_in = rge ? sws_pkg::REM_W'(rcand - rtrial) : sws_pkg::REM_W'(rcand);
            root_in = {root_ff[sws_pkg::ROOT_W-2:0], rge};
            rad_in  = {rad_ff[sws_pkg::DIV_W-3:0], 2'b00};
         end
         default: begin
         end
      endcase
   end

   // Control registers of the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= sws_pkg::LENGTH_RESET;
         head_ff   <= '0;
         count_ff  <= '0;
         phase_ff  <= '0;
         sum_ff    <= '0;
         qsum_ff   <= '0;
      end else begin
         if (csr_wen) begin
            length_ff <= csr_wdata;
         end
         head_ff  <= head_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         qsum_ff  <= qsum_in;
      end
   end

   // Working registers of the arithmetic units.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mula_ff <= mula_in;
      mulb_ff <= mulb_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rrem_ff <= rrem_in;
      if (cmd == sws_pkg::CMD_LOAD) begin
         sample_ff <= req_tdata;
      end
      if (cmd == sws_pkg::CMD_DROP || cmd == sws_pkg::CMD_PUSH) begin
         sq_ff <= sws_pkg::SQ_W'(sq_prod);
      end
      if (cmd == sws_pkg::CMD_MULS_INIT) begin
         t_ff <= acc_ff;
      end
      if (cmd == sws_pkg::CMD_MEAN_SAVE) begin
         mean_ff <= neg ? -quot : quot;
      end
      if (cmd == sws_pkg::CMD_OUT) begin
         out_ff <= {phase_ff == '0, count_ff == eff_len, count_ff, dev_ok,
                    dev_ok ? sws_pkg::DEV_W'(root_ff) : sws_pkg::DEV_W'(0),
                    mean_ff, sum_ff};
      end
   end

   // Sample store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd == sws_pkg::CMD_PUSH) begin
         mem[tail] <= sample_ff;
      end
      if (cmd == sws_pkg::CMD_READ) begin
         old_ff <= mem[head_ff];
      end
   end

   assign status.drop_needed = count_ff >= eff_len;
   assign status.mul_busy    = mulb_ff != '0;
   assign status.dev_needed  = dev_ok;
   assign rsp_tdata          = out_ff;

endmodule

>>> rtl/core/sws_controller.sv
module sws_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sws_pkg::status_type  status,
   output sws_pkg::cmd_type     cmd
);

   sws_pkg::state_type          state_ff, state_in;
   logic [sws_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        valid_ff, valid_in;

   // State, step counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sws_pkg::ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Sequencing of one item through drop, push, mean and, when the deviation is needed, variance and root.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = sws_pkg::CMD_NONE;
      req_tready = 1'b0;
      valid_in   = valid_ff & ~rsp_tready;
      unique case (state_ff)
         sws_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = sws_pkg::CMD_LOAD;
               state_in = sws_pkg::ST_CHECK;
            end
         end
         sws_pkg::ST_CHECK: begin
            if (status.drop_needed) begin
               cmd      = sws_pkg::CMD_READ;
               state_in = sws_pkg::ST_DROP;
            end else begin
               state_in = sws_pkg::ST_PUSH;
            end
         end
         sws_pkg::ST_DROP: begin
            cmd      = sws_pkg::CMD_DROP;
            state_in = sws_pkg::ST_DROPQ;
         end
         sws_pkg::ST_DROPQ: begin
            cmd      = sws_pkg::CMD_DROPQ;
            state_in = sws_pkg::ST_CHECK;
         end
         sws_pkg::ST_PUSH: begin
            cmd      = sws_pkg::CMD_PUSH;
            state_in = sws_pkg::ST_PUSHQ;
         end
         sws_pkg::ST_PUSHQ: begin
            cmd      = sws_pkg::CMD_PUSHQ;
            state_in = sws_pkg::ST_MEAN_INIT;
         end
         sws_pkg::ST_MEAN_INIT: begin
            cmd      = sws_pkg::CMD_MEAN_INIT;
            step_in  = sws_pkg::STEP_W'(sws_pkg::DIV_STEPS - 1);
            state_in = sws_pkg::ST_MEAN_DIV;
         end
         sws_pkg::ST_MEAN_DIV: begin
            cmd     = sws_pkg::CMD_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = sws_pkg::ST_MEAN_SAVE;
            end
         end
         sws_pkg::ST_MEAN_SAVE: begin
            cmd      = sws_pkg::CMD_MEAN_SAVE;
            state_in = status.dev_needed ? sws_pkg::ST_MULN_INIT : sws_pkg::ST_OUT;
         end
         sws_pkg::ST_MULN_INIT: begin
            cmd      = sws_pkg::CMD_MULN_INIT;
            state_in = sws_pkg::ST_MULN;
         end
         sws_pkg::ST_MULN: begin
            if (status.mul_busy) begin
               cmd = sws_pkg::CMD_MUL_STEP;
            end else begin
               state_in = sws_pkg::ST_MULS_INIT;
            end
         end
         sws_pkg::ST_MULS_INIT: begin
            cmd      = sws_pkg::CMD_MULS_INIT;
            state_in = sws_pkg::ST_MULS;
         end
         sws_pkg::ST_MULS: begin
            if (status.mul_busy) begin
               cmd = sws_pkg::CMD_MUL_STEP;
            end else begin
               state_in = sws_pkg::ST_VAR_INIT;
            end
         end
         sws_pkg::ST_VAR_INIT: begin
            cmd      = sws_pkg::CMD_VAR_INIT;
            step_in  = sws_pkg::STEP_W'(sws_pkg::DIV_STEPS - 1);
            state_in = sws_pkg::ST_VAR_DIV;
         end
         sws_pkg::ST_VAR_DIV: begin
            cmd     = sws_pkg::CMD_DIV_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = sws_pkg::ST_ROOT_INIT;
            end
         end
         sws_pkg::ST_ROOT_INIT: begin
            cmd      = sws_pkg::CMD_ROOT_INIT;
            step_in  = sws_pkg::STEP_W'(sws_pkg::ROOT_STEPS - 1);
            state_in = sws_pkg::ST_ROOT;
         end
         sws_pkg::ST_ROOT: begin
            cmd     = sws_pkg::CMD_ROOT_STEP;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = sws_pkg::ST_OUT;
            end
         end
         sws_pkg::ST_OUT: begin
            // Load the output register once the previous item has gone.
            if (!valid_ff || rsp_tready) begin
               cmd      = sws_pkg::CMD_OUT;
               valid_in = 1'b1;
               state_in = sws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sws_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = valid_ff;

endmodule

>>> rtl/core/sliding_window_statistics_unit.sv
// Channel   Ports                          Contents
// req       req_tvalid/tready/tdata[31:0]  one signed sample per item
// rsp       rsp_tvalid/tready/tdata[127:0] sum, mean, deviation and flags
// csr       csr_wen/csr_wdata[6:0]         window length register
//
// Each sample dropped from the window adds a pass through the check and drop states;
// the two 92-step restoring divisions and the 46-step square root dominate, with
// a shift-add multiplier in between.
// Reset clears the count, sum, phase and length (to 16); the store needs none.
// A new item is taken only once the previous one is in the output register.
module sliding_window_statistics_unit #(
   parameter int WINDOW_MAX = sws_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [sws_pkg::CNT_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // sample[31:0]
   input  logic [sws_pkg::SAMPLE_W-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // window_sum[37:0], window_mean[77:38], window_deviation[117:78],
   // deviation_valid[118], sample_count[125:119], window_full[126], round_done[127]
   output logic [sws_pkg::RSP_W-1:0]     rsp_tdata
);

   sws_pkg::cmd_type    cmd;
   sws_pkg::status_type status;

   // Sequencer.
   sws_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Store and arithmetic.
   sws_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> rtl/core/sws_checker.sv
`include "sliding_window_statistics_unit_assert.svh"

module sws_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A stalled result stays offered and unchanged.
   `SWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `SWS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // Every result follows at least one sample.
   `SWS_ASSERT_SAME(a_count_nonzero, clock, reset, rsp_tvalid, rsp_tdata[125:119] != 7'd0)

   // With a single sample the deviation reads zero and is flagged invalid.
   `SWS_ASSERT_SAME(a_dev_single, clock, reset, rsp_tvalid && !rsp_tdata[118], rsp_tdata[117:78] == 40'd0 && rsp_tdata[125:119] == 7'd1)

endmodule

bind sliding_window_statistics_unit sws_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sliding_window_statistics_checker.sv
`timescale 1ns / 1ps

// Watches all three channels of the statistics unit, predicts each result from the
// accepted samples and compares it field by field.
module sliding_window_statistics_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [6:0]   csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   typedef struct packed {
      logic         round_done;
      logic         window_full;
      logic [6:0]   sample_count;
      logic         deviation_valid;
      logic [39:0]  window_deviation;
      logic [39:0]  window_mean;
      logic [37:0]  window_sum;
   } stats_type;

   localparam int HOLD_MAX = 64;

   logic [6:0]          length_reg;
   logic signed [63:0]  held_samples [$];
   int unsigned         phase;
   stats_type           expected_stats [$];

   // Integer square root of a wide unsigned value, floor.
   function automatic logic [63:0] floor_root(input logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int b = 45; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // Adds one sample to the predicted window and returns the statistics.
   function automatic stats_type add_sample(input logic [31:0] raw);
      int unsigned          len;
      int unsigned          n;
      logic signed [63:0]   total;
      logic [63:0]          mag;
      logic [63:0]          q;
      logic [127:0]         acc;
      logic [127:0]         d;
      logic signed [127:0]  diff;
      stats_type            s;
      len = (length_reg == 0) ? 1 : (length_reg > HOLD_MAX ? HOLD_MAX : length_reg);
      while (held_samples.size() >= len) void'(held_samples.pop_front());
      held_samples.push_back(64'(signed'(raw)));
      n = held_samples.size();
      phase++;
      if (phase >= len) phase = 0;
      total = 0;
      foreach (held_samples[i]) total += held_samples[i];
      mag = total < 0 ? 64'(-total) : 64'(total);
      q = (mag * 512 + n) / (2 * n);
      s.window_sum = total[37:0];
      s.window_mean = total < 0 ? 40'(-q) : 40'(q);
      s.window_deviation = '0;
      if (n >= 2) begin
         acc = '0;
         foreach (held_samples[i]) begin
            diff = 128'(signed'(held_samples[i])) * n - 128'(total);
            d = diff < 0 ? 128'(-diff) : 128'(diff);
            acc += d * d;
         end
         acc = (acc << 16) / (128'(n) * n * (n - 1));
         s.window_deviation = 40'(floor_root(acc));
      end
      s.deviation_valid = n >= 2;
      s.sample_count = 7'(n);
      s.window_full = n == len;
      s.round_done = phase == 0;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_stats.size();

   // Model the register, the input item and the result item at each edge.
   always @(posedge clock) begin
      stats_type got;
      stats_type want;
      if (reset) begin
         length_reg <= 7'd16;
         held_samples.delete();
         phase = 0;
         expected_stats.delete();
         fail_count = 0;
      end else begin
         if (csr_wen) length_reg <= csr_wdata;
         if (req_tvalid && req_tready) expected_stats.push_back(add_sample(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_stats.size() == 0) begin
               $display("%0t: result item with no expectation", $realtime);
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               if (got.window_sum != want.window_sum)
                  report_mismatch("sum", got.window_sum, want.window_sum);
               if (got.window_mean != want.window_mean)
                  report_mismatch("mean", got.window_mean, want.window_mean);
               if (got.window_deviation != want.window_deviation)
                  report_mismatch("deviation", got.window_deviation, want.window_deviation);
               if (got.deviation_valid != want.deviation_valid)
                  report_mismatch("deviation valid", got.deviation_valid,
                                  want.deviation_valid);
               if (got.sample_count != want.sample_count)
                  report_mismatch("count", got.sample_count, want.sample_count);
               if (got.window_full != want.window_full)
                  report_mismatch("full", got.window_full, want.window_full);
               if (got.round_done != want.round_done)
                  report_mismatch("round done", got.round_done, want.round_done);
            end
         end
      end
   end

endmodule

>>> tb/sliding_window_statistics_unit_test.sv
`timescale 1ns / 1ps

module sliding_window_statistics_unit_test;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wen = 1'b0;
   logic [6:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   int           fail_count;
   int           pending_count;
   bit           quiet_phase = 1'b0;
   bit           hold_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sliding_window_statistics_unit dut (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   sliding_window_statistics_checker checker_inst (
      .clock(clock), .reset(reset), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Offers one sample and waits for it to be accepted. The valid stays up on
   // return, so the caller either offers the next sample or drops it.
   task automatic send_sample(input logic [31:0] value);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Writes the length register once every result has come and the unit is idle.
   task automatic write_length(input logic [6:0] value);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [31:0] random_sample();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3: return 32'($signed($urandom_range(0, 200)) - 100);
         default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      endcase
   endfunction

   // Receiver side: random stall bursts, one long hold-off when asked.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic [6:0] lengths [7] = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd37};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes under the reset length, single sample included.
      send_sample(32'h8000_0000);
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h0000_0001);
      for (int i = 0; i < 12; i++) send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
      // The window shrinks while it is full.
      write_length(7'd3);
      for (int i = 0; i < 4; i++) send_sample(32'(i * 3 - 5));

      // Pressure: the receiver holds off while samples keep coming.
      hold_off = 1'b1;
      for (int i = 0; i < 20; i++) send_sample(random_sample());

      // Random phases over several lengths, extremes among them.
      foreach (lengths[k]) begin
         write_length(lengths[k]);
         for (int i = 0; i < 170; i++) begin
            if (k == 6) quiet_phase = i > 100;
            send_sample(random_sample());
         end
      end

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
